[rtl/core/pcxrle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pcxrle_pkg;

    localparam int BYTE_W      = 8;
    localparam int COLUMN_W    = 14;
    localparam int PLANE_W     = 2;
    localparam int ROW_W       = 16;
    localparam int RUN_W       = 6;
    localparam int LINE_CFG_W  = 15;
    localparam int PLANE_CFG_W = 3;
    localparam int ROW_CFG_W   = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 2;

    localparam logic [BYTE_W-1:0] RUN_CODE_BASE = 8'hC0;

    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSED  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT   = 2'd3;

    typedef struct packed {
        logic emit;
        logic emit_from_run;
        logic set_code;
        logic clr_await;
        logic start_run;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic image_done;
        logic compressed;
        logic awaiting;
        logic byte_is_code;
        logic run_zero;
        logic run_done;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/pcxrle_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire pcxrle_pkg::sts_t sts,
    output pcxrle_pkg::cmd_t     cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_tready = (state_reg == S_IDLE) && sts.slot_free;
    assign accept   = s_tready && s_tvalid;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !sts.image_done)
                begin
                    if (!sts.compressed)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.clr_await = 1'b1;
                    end
                    else if (!sts.awaiting)
                    begin
                        if (sts.byte_is_code)
                        begin
                            cmd.set_code = 1'b1;
                        end
                        else
                        begin
                            cmd.emit = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.clr_await = 1'b1;
                        if (!sts.run_zero)
                        begin
                            cmd.start_run = 1'b1;
                            state_next    = S_RUN;
                        end
                    end
                end
            end
            S_RUN:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_from_run = 1'b1;
                    if (sts.run_done)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pcxrle_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_dp #(
    parameter int MAX_LINE_BYTES = 16384
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [pcxrle_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pcxrle_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [pcxrle_pkg::BYTE_W-1:0]          in_byte,
    input  wire pcxrle_pkg::cmd_t                       cmd,
    output pcxrle_pkg::sts_t                            sts,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [pcxrle_pkg::OUT_DATA_W-1:0]           m_tdata,
    output logic                                        m_tlast,
    output logic [pcxrle_pkg::OUT_USER_W-1:0]           m_tuser
);

    localparam int CW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int LW = pcxrle_pkg::LINE_CFG_W + 1;
    localparam logic [pcxrle_pkg::LINE_CFG_W-1:0] LINE_MAX =
        pcxrle_pkg::LINE_CFG_W'(MAX_LINE_BYTES);
    localparam logic [pcxrle_pkg::PLANE_CFG_W-1:0] PLANE_MAX = 3'd4;
    localparam logic [pcxrle_pkg::ROW_CFG_W-1:0]   ROW_MAX   = 17'd65536;

    logic                                   compressed_reg;
    logic [pcxrle_pkg::LINE_CFG_W-1:0]      line_bytes_reg;
    logic [pcxrle_pkg::PLANE_CFG_W-1:0]     plane_count_reg;
    logic [pcxrle_pkg::ROW_CFG_W-1:0]       row_count_reg;

    logic                                   awaiting_reg;
    logic [pcxrle_pkg::RUN_W-1:0]           run_length_reg;
    logic [pcxrle_pkg::RUN_W-1:0]           count_reg;
    logic [pcxrle_pkg::BYTE_W-1:0]          value_reg;
    logic [CW-1:0]                          column_reg;
    logic [pcxrle_pkg::PLANE_W-1:0]         plane_reg;
    logic [pcxrle_pkg::ROW_W-1:0]           row_reg;
    logic                                   image_done_reg;

    logic                                   out_valid_reg;
    logic [pcxrle_pkg::BYTE_W-1:0]          out_byte_reg;
    logic [pcxrle_pkg::COLUMN_W-1:0]        out_column_reg;
    logic [pcxrle_pkg::PLANE_W-1:0]         out_plane_reg;
    logic [pcxrle_pkg::ROW_W-1:0]           out_row_reg;
    logic                                   out_last_reg;
    logic                                   out_lend_reg;
    logic                                   out_iend_reg;

    logic [pcxrle_pkg::LINE_CFG_W-1:0]      line_len;
    logic [pcxrle_pkg::PLANE_CFG_W-1:0]     planes;
    logic [pcxrle_pkg::ROW_CFG_W-1:0]       rows;
    logic                                   lend;
    logic                                   pend;
    logic                                   iend;
    logic                                   count_one;
    logic                                   emit_last;

    always_comb
    begin
        if (line_bytes_reg == '0)
            line_len = pcxrle_pkg::LINE_CFG_W'(1);
        else if (line_bytes_reg > LINE_MAX)
            line_len = LINE_MAX;
        else
            line_len = line_bytes_reg;

        if (plane_count_reg == '0)
            planes = pcxrle_pkg::PLANE_CFG_W'(1);
        else if (plane_count_reg > PLANE_MAX)
            planes = PLANE_MAX;
        else
            planes = plane_count_reg;

        if (row_count_reg == '0)
            rows = pcxrle_pkg::ROW_CFG_W'(1);
        else if (row_count_reg > ROW_MAX)
            rows = ROW_MAX;
        else
            rows = row_count_reg;
    end

    assign lend = (LW'(column_reg) + LW'(1)) >= LW'(line_len);
    assign pend = lend &&
        ((pcxrle_pkg::PLANE_CFG_W'(plane_reg) + pcxrle_pkg::PLANE_CFG_W'(1)) >= planes);
    assign iend = pend &&
        ((pcxrle_pkg::ROW_CFG_W'(row_reg) + pcxrle_pkg::ROW_CFG_W'(1)) >= rows);

    assign count_one = (count_reg == pcxrle_pkg::RUN_W'(1));
    assign emit_last = cmd.emit_from_run ? (count_one || lend) : 1'b1;

    assign sts.slot_free    = !out_valid_reg || m_tready;
    assign sts.image_done   = image_done_reg;
    assign sts.compressed   = compressed_reg;
    assign sts.awaiting     = awaiting_reg;
    assign sts.byte_is_code = (in_byte >= pcxrle_pkg::RUN_CODE_BASE);
    assign sts.run_zero     = (run_length_reg == '0);
    assign sts.run_done     = count_one || lend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_reg  <= 1'b1;
            line_bytes_reg  <= pcxrle_pkg::LINE_CFG_W'(1);
            plane_count_reg <= pcxrle_pkg::PLANE_CFG_W'(1);
            row_count_reg   <= pcxrle_pkg::ROW_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcxrle_pkg::REG_COMPRESSED:  compressed_reg  <= cfg_data[0];
                pcxrle_pkg::REG_LINE_BYTES:
                    line_bytes_reg  <= cfg_data[pcxrle_pkg::LINE_CFG_W-1:0];
                pcxrle_pkg::REG_PLANE_COUNT:
                    plane_count_reg <= cfg_data[pcxrle_pkg::PLANE_CFG_W-1:0];
                pcxrle_pkg::REG_ROW_COUNT:
                    row_count_reg   <= cfg_data[pcxrle_pkg::ROW_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg   <= 1'b0;
            run_length_reg <= '0;
            count_reg      <= '0;
            column_reg     <= '0;
            plane_reg      <= '0;
            row_reg        <= '0;
            image_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.set_code)
            begin
                run_length_reg <= in_byte[pcxrle_pkg::RUN_W-1:0];
                awaiting_reg   <= 1'b1;
            end
            if (cmd.clr_await)
            begin
                awaiting_reg <= 1'b0;
            end
            if (cmd.start_run)
            begin
                count_reg      <= run_length_reg;
                run_length_reg <= '0;
            end
            else if (cmd.emit && cmd.emit_from_run)
            begin
                count_reg <= count_reg - pcxrle_pkg::RUN_W'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (!lend)
                begin
                    column_reg <= column_reg + CW'(1);
                end
                else
                begin
                    column_reg <= '0;
                    if (!pend)
                    begin
                        plane_reg <= plane_reg + pcxrle_pkg::PLANE_W'(1);
                    end
                    else
                    begin
                        plane_reg <= '0;
                        if (iend)
                            image_done_reg <= 1'b1;
                        else
                            row_reg <= row_reg + pcxrle_pkg::ROW_W'(1);
                    end
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_run)
        begin
            value_reg <= in_byte;
        end
        if (cmd.emit)
        begin
            out_byte_reg   <= cmd.emit_from_run ? value_reg : in_byte;
            out_column_reg <= pcxrle_pkg::COLUMN_W'(column_reg);
            out_plane_reg  <= plane_reg;
            out_row_reg    <= row_reg;
            out_last_reg   <= emit_last;
            out_lend_reg   <= lend;
            out_iend_reg   <= iend;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_plane_reg, out_column_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_iend_reg, out_lend_reg};

endmodule

`default_nettype wire

[rtl/core/pcx_rle_scanline_decoder_top.sv]
// Timing: a literal or raw byte is shown in the cycle after its input transfer; the
// value byte of a run is held in value_reg, and the run state then emits its copies.
// Throughput: a run code and its value byte are each one input transfer, then the run
// gives one copy per cycle while the output is not stalled; input is held meanwhile.
// The output register is the only buffer; reset (rst_n, asynchronous, active low) clears
// all control state and sets every configuration register to 1.
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_scanline_decoder_top #(
    parameter int MAX_LINE_BYTES = 16384
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pcxrle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pcxrle_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // file_byte [7:0]
    input  wire logic [pcxrle_pkg::BYTE_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // data_byte [7:0], column [21:8], plane [23:22], row [39:24]
    output logic [pcxrle_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                    m_tlast,
    // line_end [0], image_end [1]
    output logic [pcxrle_pkg::OUT_USER_W-1:0]       m_tuser
);

    pcxrle_pkg::cmd_t cmd;
    pcxrle_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    pcxrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcxrle_dp #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/core/pcxrle_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_chk (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [pcxrle_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire logic                               m_tlast,
    input wire logic [pcxrle_pkg::OUT_USER_W-1:0]  m_tuser
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    a_image_end_is_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("image end without line end");

    a_line_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("run continues past line end");

    a_silent_after_image: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser[1] |=> !m_tvalid)
        else $error("output after end of image");

endmodule

bind pcx_rle_scanline_decoder_top pcxrle_chk u_chk (.*);

`default_nettype wire
